[hw/rtl/rgb_to_hsv_converter_core_defines.svh]
// Assertion macros used by the checker file of the colour converter
`ifndef RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH

// Check on every edge outside reset
`define RHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rhc assertion failed");

// Check on every edge, reset included
`define RHC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rhc assertion failed");

`endif

[hw/rtl/rhc_pkg.sv]
// Types and constants of the RGB to HSV converter
package rhc_pkg;

  localparam int PIX_W        = 12;
  localparam int STEPS        = PIX_W + 1;
  localparam int DIV_W        = 2 * PIX_W + 4;
  localparam int DIFF_W       = PIX_W + 1;
  localparam int C6_W         = PIX_W + 3;
  localparam int NUM_W        = PIX_W + 4;
  localparam int FRONT_STAGES = 3;
  localparam int PIPE_LAT     = FRONT_STAGES + STEPS + 1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } in_pix_t;

  typedef struct packed {
    pix_t hue;
    pix_t saturation;
    pix_t brightness;
  } out_hsv_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // One restoring divider lane: running remainder, aligned divisor, quotient so far
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dsr;
    logic [STEPS-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t hue;
    div_lane_t sat;
    logic      hue_zero;
    logic      sat_zero;
    pix_t      brightness;
  } div_job_t;

endpackage

[hw/rtl/rhc_front.sv]
// Front stages: channel max and min, sector, chroma and divider set-up
module rhc_front
  import rhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_pix_t  in_pixel,
  output logic     job_valid,
  output div_job_t job
);

  // Stage 1
  logic    s1_valid_r;
  sector_t s1_sec_r, s1_sec_nxt;
  pix_t    s1_val_r, s1_val_nxt;
  pix_t    s1_min_r, s1_min_nxt;
  pix_t    s1_red_r, s1_green_r, s1_blue_r;

  // Stage 2
  logic              s2_valid_r;
  sector_t           s2_sec_r;
  pix_t              s2_val_r;
  pix_t              s2_chroma_r, s2_chroma_nxt;
  logic [C6_W-1:0]   s2_c6_r, s2_c6_nxt;
  logic [DIFF_W-1:0] s2_diff_r, s2_diff_nxt;

  // Stage 3
  logic     s3_valid_r;
  div_job_t s3_job_r, s3_job_nxt;

  logic [NUM_W-1:0] offset;
  logic [NUM_W-1:0] diff_ext;
  logic [NUM_W-1:0] n_num;
  logic [NUM_W-1:0] c_ext;

  // Ties go to red, then green
  always_comb begin
    if (in_pixel.red >= in_pixel.green && in_pixel.red >= in_pixel.blue) begin
      s1_sec_nxt = SEC_RED;
      s1_val_nxt = in_pixel.red;
    end else if (in_pixel.green >= in_pixel.blue) begin
      s1_sec_nxt = SEC_GREEN;
      s1_val_nxt = in_pixel.green;
    end else begin
      s1_sec_nxt = SEC_BLUE;
      s1_val_nxt = in_pixel.blue;
    end
    s1_min_nxt = in_pixel.red;
    if (in_pixel.green < s1_min_nxt) s1_min_nxt = in_pixel.green;
    if (in_pixel.blue < s1_min_nxt) s1_min_nxt = in_pixel.blue;
  end

  always_comb begin
    s2_chroma_nxt = s1_val_r - s1_min_r;
    s2_c6_nxt     = {1'b0, s2_chroma_nxt, 2'b00} + {2'b00, s2_chroma_nxt, 1'b0};
    case (s1_sec_r)
      SEC_RED:   s2_diff_nxt = {1'b0, s1_green_r} - {1'b0, s1_blue_r};
      SEC_GREEN: s2_diff_nxt = {1'b0, s1_blue_r} - {1'b0, s1_red_r};
      SEC_BLUE:  s2_diff_nxt = {1'b0, s1_red_r} - {1'b0, s1_green_r};
      default:   s2_diff_nxt = '0;
    endcase
  end

  // Sector offset folds the wrap of a negative red-sector hue into one add
  always_comb begin
    c_ext    = NUM_W'(s2_chroma_r);
    diff_ext = {{(NUM_W-DIFF_W){s2_diff_r[DIFF_W-1]}}, s2_diff_r};
    case (s2_sec_r)
      SEC_RED:   offset = s2_diff_r[DIFF_W-1] ? NUM_W'(s2_c6_r) : '0;
      SEC_GREEN: offset = c_ext << 1;
      SEC_BLUE:  offset = c_ext << 2;
      default:   offset = '0;
    endcase
    n_num = offset + diff_ext;

    s3_job_nxt.hue.rem = (DIV_W'(n_num) << (PIX_W + 1)) + DIV_W'(s2_c6_r);
    s3_job_nxt.hue.dsr = DIV_W'(s2_c6_r) << (PIX_W + 1);
    s3_job_nxt.hue.quo = '0;
    s3_job_nxt.sat.rem = (DIV_W'(s2_chroma_r) << (PIX_W + 1))
                       - (DIV_W'(s2_chroma_r) << 1) + DIV_W'(s2_val_r);
    s3_job_nxt.sat.dsr = DIV_W'(s2_val_r) << (PIX_W + 1);
    s3_job_nxt.sat.quo = '0;
    s3_job_nxt.hue_zero   = (s2_chroma_r == '0);
    s3_job_nxt.sat_zero   = (s2_val_r == '0);
    s3_job_nxt.brightness = s2_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sec_r    <= s1_sec_nxt;
    s1_val_r    <= s1_val_nxt;
    s1_min_r    <= s1_min_nxt;
    s1_red_r    <= in_pixel.red;
    s1_green_r  <= in_pixel.green;
    s1_blue_r   <= in_pixel.blue;
    s2_sec_r    <= s1_sec_r;
    s2_val_r    <= s1_val_r;
    s2_chroma_r <= s2_chroma_nxt;
    s2_c6_r     <= s2_c6_nxt;
    s2_diff_r   <= s2_diff_nxt;
    s3_job_r    <= s3_job_nxt;
  end

  assign job_valid = s3_valid_r;
  assign job       = s3_job_r;

endmodule

[hw/rtl/rhc_div_step.sv]
// One registered restoring-division step for the hue and saturation lanes
module rhc_div_step
  import rhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  div_job_t in_job,
  output logic     out_valid,
  output div_job_t out_job
);

  logic     valid_r;
  div_job_t job_r, job_nxt;

  function automatic div_lane_t lane_step(input div_lane_t ln);
    div_lane_t res;
    logic      ge;
    ge      = (ln.rem >= ln.dsr);
    res.rem = ge ? (ln.rem - ln.dsr) : ln.rem;
    res.dsr = ln.dsr >> 1;
    res.quo = {ln.quo[STEPS-2:0], ge};
    return res;
  endfunction

  always_comb begin
    job_nxt     = in_job;
    job_nxt.hue = lane_step(in_job.hue);
    job_nxt.sat = lane_step(in_job.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign out_valid = valid_r;
  assign out_job   = job_r;

endmodule

[hw/rtl/rhc_div_pipe.sv]
// Chain of division steps, one quotient bit per stage
module rhc_div_pipe
  import rhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  div_job_t in_job,
  output logic     out_valid,
  output div_job_t out_job
);

  logic     valid_chain [0:STEPS];
  div_job_t job_chain   [0:STEPS];

  assign valid_chain[0] = in_valid;
  assign job_chain[0]   = in_job;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    rhc_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_chain[i]),
      .in_job    (job_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_job   (job_chain[i+1])
    );
  end

  assign out_valid = valid_chain[STEPS];
  assign out_job   = job_chain[STEPS];

endmodule

[hw/rtl/rgb_to_hsv_converter_core.sv]
// RGB to HSV converter: one pixel in and one HSV result out every clock cycle,
// through three set-up stages, a 13-stage restoring divider that resolves one
// quotient bit of hue and saturation per stage, and an output register.
// busy is high only while rst_n is low; at all other times a pixel is taken
// on every edge with start high. Each result stands on out_hsv for the one
// cycle that out_valid is high and is not held.
module rgb_to_hsv_converter_core
  import rhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_pix_t  in_pixel,
  output logic     out_valid,
  output out_hsv_t out_hsv
);

  logic     accept;
  logic     job_valid;
  div_job_t job;
  logic     done_valid;
  div_job_t done_job;

  logic     out_valid_r;
  out_hsv_t out_hsv_r, out_hsv_nxt;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_pixel  (in_pixel),
    .job_valid (job_valid),
    .job       (job)
  );

  rhc_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (job_valid),
    .in_job    (job),
    .out_valid (done_valid),
    .out_job   (done_job)
  );

  // Drop the quotient for gray and black pixels; a full-turn hue wraps by truncation
  always_comb begin
    out_hsv_nxt.hue        = done_job.hue_zero ? '0 : done_job.hue.quo[PIX_W-1:0];
    out_hsv_nxt.saturation = done_job.sat_zero ? '0 : done_job.sat.quo[PIX_W-1:0];
    out_hsv_nxt.brightness = done_job.brightness;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_hsv_r <= out_hsv_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hsv   = out_hsv_r;

endmodule

[hw/rtl/rhc_checker.sv]
// Port-level checker for the RGB to HSV converter, bound to the top level
`include "rgb_to_hsv_converter_core_defines.svh"

module rhc_checker
  import rhc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input in_pix_t  in_pixel,
  input logic     out_valid,
  input out_hsv_t out_hsv
);

  `RHC_ASSERT_ALWAYS(a_busy_only_in_reset, busy == !rst_n)

  `RHC_ASSERT(a_item_delivered, (start && !busy) |-> ##PIPE_LAT out_valid)

  `RHC_ASSERT(a_no_invented_item, out_valid |-> $past(start && !busy, PIPE_LAT))

  `RHC_ASSERT(a_brightness_is_max,
    out_valid |-> (out_hsv.brightness >= $past(in_pixel.red, PIPE_LAT) &&
                   out_hsv.brightness >= $past(in_pixel.green, PIPE_LAT) &&
                   out_hsv.brightness >= $past(in_pixel.blue, PIPE_LAT)))

  `RHC_ASSERT(a_gray_has_no_hue, (out_valid && out_hsv.saturation == '0) |-> out_hsv.hue == '0)

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_pixel  (in_pixel),
  .out_valid (out_valid),
  .out_hsv   (out_hsv)
);
